// File: design/aept_pkg.sv
// ----------------------------------------------------------------------------
// aept_pkg
// Shared widths, constants and types of the acceleration energy peak tracker.
// ----------------------------------------------------------------------------
package aept_pkg;

   localparam int ACC_W         = 16;      // one axis sample
   localparam int AXES          = 3;
   localparam int SQ_W          = 2 * ACC_W;
   localparam int MEAN_W        = 33;      // energy and window mean, signed
   localparam int PEAK_W        = 32;
   localparam int REQ_DATA_W    = 48;      // three axes, whole bytes
   localparam int RSP_DATA_W    = 72;      // mean and peak, padded to bytes
   localparam int GRAVITY_SQ    = 409600;  // 100 m^2/s^4 in 1/4096 units
   localparam int DEF_WINDOW    = 8;
   localparam int DEF_MAX_BATCH = 16;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef struct packed {
      logic done;
      logic rem_nz;
   } div_status_type;

endpackage

// File: design/aept_div.sv
// ----------------------------------------------------------------------------
// aept_div
// Restoring unsigned divider, one quotient bit per cycle. The dividend shifts
// out of the top of the working register while quotient bits shift in below.
// ----------------------------------------------------------------------------
module aept_div
   import aept_pkg::*;
#(
   parameter int DW = 21,
   parameter int VW = 5
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DW-1:0]  dividend,
   input  logic [VW-1:0]  divisor,
   output logic [DW-1:0]  quotient,
   output div_status_type status
);

   localparam int CW = $clog2(DW);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      diff    = trial - {1'b0, divisor};
      fits    = (trial >= {1'b0, divisor});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], fits};
         rem_in = fits ? diff[VW-1:0] : trial[VW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient      = quo_ff;
   assign status.done   = done_ff;
   assign status.rem_nz = |rem_ff;

endmodule

// File: design/accel_energy_peak_tracker.sv
// ----------------------------------------------------------------------------
// accel_energy_peak_tracker
// Batch-averaged acceleration energy over a sliding window, with peak tracking.
// ----------------------------------------------------------------------------
// req carries samples (tdata: acc_x, acc_y, acc_z from bit 0 up), tuser is the
// operation (sample or clear) and tlast marks the last sample of a batch.
// A sample that is not last, and a clear, are taken without leaving idle;
// req_tready stays high for them even while a result waits on rsp.
// A last sample starts the evaluation: three bit-serial dividers average the
// axes, one shared 16x16 multiplier squares them, the window store is updated
// and a further bit-serial divider forms the window mean. req_tready is low
// from acceptance until the result register is loaded.
// rsp carries window_mean and peak_value in tdata, new_peak and notify in
// tuser. The result register holds while rsp_tready is low; a following
// evaluation waits for it to drain. csr writes the subscribed bit and is
// always ready. Reset clears the window, peak, batch and subscribed bit.
// ----------------------------------------------------------------------------
module accel_energy_peak_tracker
   import aept_pkg::*;
#(
   parameter int WINDOW    = DEF_WINDOW,
   parameter int MAX_BATCH = DEF_MAX_BATCH
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // acc_x, acc_y, acc_z
   input  logic                  req_tuser,   // operation
   input  logic                  req_tlast,   // last_in_batch
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // window_mean, peak_value, zero pad
   output logic [1:0]            rsp_tuser,   // new_peak, notify
   // register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);

   localparam int CNT_W  = $clog2(MAX_BATCH + 1);
   localparam int SUM_W  = ACC_W + CNT_W;
   localparam int TOT_W  = MEAN_W + $clog2(WINDOW);
   localparam int WIN_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_SQ     = 3'd2;
   localparam logic [2:0] ST_NRG    = 3'd3;
   localparam logic [2:0] ST_TOT    = 3'd4;
   localparam logic [2:0] ST_MSTART = 3'd5;
   localparam logic [2:0] ST_MEAN   = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]               state_ff, state_in;
   logic signed [SUM_W-1:0]  sum_ff [AXES];
   logic signed [SUM_W-1:0]  sum_in [AXES];
   logic signed [SUM_W-1:0]  sum_new [AXES];
   logic signed [ACC_W-1:0]  acc_s [AXES];
   logic [CNT_W-1:0]         count_ff, count_in, count_new;
   logic [CNT_W-1:0]         divisor_ff, divisor_in;
   logic                     sub_ff, sub_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [WINDOW-1:0]        wvld_ff, wvld_in;
   logic signed [TOT_W-1:0]  total_ff, total_in;
   logic [PEAK_W-1:0]        peak_ff, peak_in;
   logic [1:0]               sq_cnt_ff, sq_cnt_in;
   logic [SQ_W-1:0]          prod_ff, prod_in;
   logic [SQ_W-1:0]          sq_acc_ff, sq_acc_in;
   logic [ACC_W-1:0]         sq_sel;
   logic signed [MEAN_W-1:0] energy_ff, energy_in;
   logic signed [MEAN_W-1:0] old_val;
   logic                     tneg_ff, tneg_in;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;
   logic [MEAN_W-1:0]        qm;
   logic                     raised;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0]        rsp_mean_ff, rsp_mean_in;
   logic [PEAK_W-1:0]        rsp_peak_ff, rsp_peak_in;
   logic                     rsp_new_ff, rsp_new_in;
   logic                     rsp_notify_ff, rsp_notify_in;
   logic                     req_accept;
   logic                     ax_start, win_start, mem_we;
   logic [SUM_W-1:0]         ax_mag [AXES];
   logic [SUM_W-1:0]         ax_quo [AXES];
   div_status_type           ax_stat [AXES];
   logic [TOT_W-1:0]         win_mag;
   logic [TOT_W-1:0]         win_quo;
   div_status_type           win_stat;
   logic signed [MEAN_W-1:0] win_mem_ff [WINDOW];
   logic signed [MEAN_W-1:0] rd_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // batch accumulation and axis magnitudes
   always_comb begin
      count_new = count_ff;
      for (int i = 0; i < AXES; i++) begin
         acc_s[i]   = req_tdata[i*ACC_W +: ACC_W];
         sum_new[i] = sum_ff[i];
      end
      if (count_ff < CNT_W'(MAX_BATCH)) begin
         count_new = count_ff + 1'b1;
         for (int i = 0; i < AXES; i++) begin
            sum_new[i] = sum_ff[i] + SUM_W'(acc_s[i]);
         end
      end
      for (int i = 0; i < AXES; i++) begin
         ax_mag[i] = sum_new[i][SUM_W-1] ? $unsigned(-sum_new[i]) : $unsigned(sum_new[i]);
      end
   end

   always_comb begin
      case (sq_cnt_ff)
         2'd0:    sq_sel = ax_quo[0][ACC_W-1:0];
         2'd1:    sq_sel = ax_quo[1][ACC_W-1:0];
         2'd2:    sq_sel = ax_quo[2][ACC_W-1:0];
         default: sq_sel = '0;
      endcase
   end

   assign old_val = wvld_ff[slot_ff] ? rd_ff : '0;
   assign win_mag = total_ff[TOT_W-1] ? $unsigned(-total_ff) : $unsigned(total_ff);
   // floor for negative totals: round the magnitude up
   assign qm      = win_quo[MEAN_W-1:0] + MEAN_W'(tneg_ff & win_stat.rem_nz);
   assign raised  = !mean_ff[MEAN_W-1] && (mean_ff[PEAK_W-1:0] > peak_ff);

   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      divisor_in    = divisor_ff;
      sub_in        = (csr_valid && csr_ready) ? csr_data : sub_ff;
      slot_in       = slot_ff;
      wvld_in       = wvld_ff;
      total_in      = total_ff;
      peak_in       = peak_ff;
      sq_cnt_in     = sq_cnt_ff;
      prod_in       = prod_ff;
      sq_acc_in     = sq_acc_ff;
      energy_in     = energy_ff;
      tneg_in       = tneg_ff;
      mean_in       = mean_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_mean_in   = rsp_mean_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_notify_in = rsp_notify_ff;
      ax_start      = 1'b0;
      win_start     = 1'b0;
      mem_we        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == OP_CLEAR) begin
                  for (int i = 0; i < AXES; i++) begin
                     sum_in[i] = '0;
                  end
                  count_in = '0;
                  wvld_in  = '0;
                  total_in = '0;
                  slot_in  = '0;
                  peak_in  = '0;
               end else if (req_tlast) begin
                  ax_start   = 1'b1;
                  divisor_in = count_new;
                  for (int i = 0; i < AXES; i++) begin
                     sum_in[i] = '0;
                  end
                  count_in = '0;
                  state_in = ST_DIV;
               end else begin
                  sum_in   = sum_new;
                  count_in = count_new;
               end
            end
         end
         ST_DIV: begin
            if (ax_stat[0].done) begin
               sq_cnt_in = '0;
               sq_acc_in = '0;
               state_in  = ST_SQ;
            end
         end
         ST_SQ: begin
            // multiply one axis per cycle, accumulate the registered product in the cycle after
            prod_in   = SQ_W'(sq_sel) * SQ_W'(sq_sel);
            sq_cnt_in = sq_cnt_ff + 1'b1;
            if (sq_cnt_ff != 2'd0) begin
               sq_acc_in = sq_acc_ff + prod_ff;
            end
            if (sq_cnt_ff == 2'd3) begin
               state_in = ST_NRG;
            end
         end
         ST_NRG: begin
            energy_in = $signed({1'b0, sq_acc_ff}) - MEAN_W'(GRAVITY_SQ);
            state_in  = ST_TOT;
         end
         ST_TOT: begin
            total_in         = total_ff - TOT_W'(old_val) + TOT_W'(energy_ff);
            mem_we           = 1'b1;
            wvld_in[slot_ff] = 1'b1;
            slot_in          = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            state_in         = ST_MSTART;
         end
         ST_MSTART: begin
            win_start = 1'b1;
            tneg_in   = total_ff[TOT_W-1];
            state_in  = ST_MEAN;
         end
         ST_MEAN: begin
            if (win_stat.done) begin
               mean_in  = tneg_ff ? -qm : qm;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = mean_ff;
               rsp_peak_in   = raised ? mean_ff[PEAK_W-1:0] : peak_ff;
               rsp_new_in    = raised;
               rsp_notify_in = raised && sub_ff;
               if (raised) begin
                  peak_in = mean_ff[PEAK_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int i = 0; i < AXES; i++) begin
            sum_ff[i] <= '0;
         end
         count_ff     <= '0;
         sub_ff       <= 1'b0;
         slot_ff      <= '0;
         wvld_ff      <= '0;
         total_ff     <= '0;
         peak_ff      <= '0;
         sq_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         sub_ff       <= sub_in;
         slot_ff      <= slot_in;
         wvld_ff      <= wvld_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         sq_cnt_ff    <= sq_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff    <= divisor_in;
      prod_ff       <= prod_in;
      sq_acc_ff     <= sq_acc_in;
      energy_ff     <= energy_in;
      tneg_ff       <= tneg_in;
      mean_ff       <= mean_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_notify_ff <= rsp_notify_in;
   end

   // window store; entries without a valid bit read as zero
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem_ff[slot_ff] <= energy_ff;
      end
      rd_ff <= win_mem_ff[slot_ff];
   end

   for (genvar g = 0; g < AXES; g++) begin : g_axis
      aept_div #(
         .DW (SUM_W),
         .VW (CNT_W)
      ) u_axis_div (
         .clock    (clock),
         .reset    (reset),
         .start    (ax_start),
         .dividend (ax_mag[g]),
         .divisor  (divisor_ff),
         .quotient (ax_quo[g]),
         .status   (ax_stat[g])
      );
   end

   aept_div #(
      .DW (TOT_W),
      .VW (WIN_W)
   ) u_win_div (
      .clock    (clock),
      .reset    (reset),
      .start    (win_start),
      .dividend (win_mag),
      .divisor  (WIN_W'(WINDOW)),
      .quotient (win_quo),
      .status   (win_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - MEAN_W - PEAK_W)'(0), rsp_peak_ff, rsp_mean_ff};
   assign rsp_tuser  = {rsp_notify_ff, rsp_new_ff};

   // the three axis dividers run in lockstep
   a_axis_lockstep : assert property (@(posedge clock) disable iff (reset)
      (ax_stat[1].done == ax_stat[0].done) && (ax_stat[2].done == ax_stat[0].done))
      else $error("axis dividers out of step");

   // the peak only grows, except through a clear request
   a_peak_monotonic : assert property (@(posedge clock) disable iff (reset)
      !(req_accept && (req_tuser == OP_CLEAR)) |=> (peak_ff >= $past(peak_ff)))
      else $error("peak decreased without clear");

   // a new peak is the reported mean
   a_new_peak_value : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_new_ff) |-> (rsp_mean_ff == {1'b0, rsp_peak_ff}))
      else $error("new peak differs from window mean");

   a_notify_needs_peak : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_notify_ff) |-> (rsp_new_ff && sub_ff))
      else $error("notify without new peak or subscription");

endmodule
